// ===== hdl/tbfo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbfo_pkg
// Shared constants, command codes and types of the boundary face orienter.
// ----------------------------------------------------------------------------
package tbfo_pkg;
	localparam int MAX_VERTICES = 4096;
	localparam int MAX_TETS     = 8192;
	localparam int COORD_BITS   = 24;
	localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
	localparam int TIDX_BITS    = $clog2(MAX_TETS);
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int CROSS_BITS   = 2 * DIFF_BITS + 1;
	localparam int DET_BITS     = CROSS_BITS + DIFF_BITS + 2;
	localparam int NCORNERS     = 4;

	typedef enum logic [1:0] {
		CMD_LOAD_VERTEX = 2'd0,
		CMD_LOAD_TET    = 2'd1,
		CMD_FACE_INNER  = 2'd2,
		CMD_FACE_OUTER  = 2'd3
	} cmd_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [VIDX_BITS-1:0] vidx_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		vidx_t a;
		vidx_t b;
		vidx_t c;
	} face_t;
endpackage

// ===== hdl/tbfo_ram.sv =====
// ----------------------------------------------------------------------------
// tbfo_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tbfo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end
endmodule

// ===== hdl/tbfo_det.sv =====
// ----------------------------------------------------------------------------
// tbfo_det
// Pipelined exact orient3d sign: differences, cross product, dot product.
// Five register stages, advances only when en is high.
// ----------------------------------------------------------------------------
module tbfo_det (
	input  logic            clk,
	input  logic            en,
	input  tbfo_pkg::point_t pa,
	input  tbfo_pkg::point_t pb,
	input  tbfo_pkg::point_t pc,
	input  tbfo_pkg::point_t pd,
	output logic            neg
);
	import tbfo_pkg::*;

	localparam int LO_BITS  = DIFF_BITS + 1;
	localparam int HI_BITS  = CROSS_BITS - LO_BITS;
	localparam int PHI_BITS = HI_BITS + DIFF_BITS;
	localparam int PLO_BITS = LO_BITS + 1 + DIFF_BITS;

	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [CROSS_BITS-1:0] cross_t;
	typedef logic signed [DET_BITS-1:0]   det_t;
	typedef logic signed [PHI_BITS-1:0]   phi_t;
	typedef logic signed [PLO_BITS-1:0]   plo_t;
	typedef logic signed [PHI_BITS+1:0]   hsum_t;
	typedef logic signed [PLO_BITS+1:0]   lsum_t;

	diff_t  u_s1 [3], v_s1 [3], w_s1 [3];
	cross_t m_s2 [6];
	diff_t  w_s2 [3];
	cross_t n_s3 [3];
	diff_t  w_s3 [3];
	phi_t   hi_s4 [3];
	plo_t   lo_s4 [3];
	hsum_t  hs_s5;
	lsum_t  ls_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1[0] <= DIFF_BITS'(pb.x) - DIFF_BITS'(pa.x);
			u_s1[1] <= DIFF_BITS'(pb.y) - DIFF_BITS'(pa.y);
			u_s1[2] <= DIFF_BITS'(pb.z) - DIFF_BITS'(pa.z);
			v_s1[0] <= DIFF_BITS'(pc.x) - DIFF_BITS'(pa.x);
			v_s1[1] <= DIFF_BITS'(pc.y) - DIFF_BITS'(pa.y);
			v_s1[2] <= DIFF_BITS'(pc.z) - DIFF_BITS'(pa.z);
			w_s1[0] <= DIFF_BITS'(pd.x) - DIFF_BITS'(pa.x);
			w_s1[1] <= DIFF_BITS'(pd.y) - DIFF_BITS'(pa.y);
			w_s1[2] <= DIFF_BITS'(pd.z) - DIFF_BITS'(pa.z);

			m_s2[0] <= CROSS_BITS'(u_s1[1]) * CROSS_BITS'(v_s1[2]);
			m_s2[1] <= CROSS_BITS'(u_s1[2]) * CROSS_BITS'(v_s1[1]);
			m_s2[2] <= CROSS_BITS'(u_s1[2]) * CROSS_BITS'(v_s1[0]);
			m_s2[3] <= CROSS_BITS'(u_s1[0]) * CROSS_BITS'(v_s1[2]);
			m_s2[4] <= CROSS_BITS'(u_s1[0]) * CROSS_BITS'(v_s1[1]);
			m_s2[5] <= CROSS_BITS'(u_s1[1]) * CROSS_BITS'(v_s1[0]);
			w_s2    <= w_s1;

			n_s3[0] <= m_s2[0] - m_s2[1];
			n_s3[1] <= m_s2[2] - m_s2[3];
			n_s3[2] <= m_s2[4] - m_s2[5];
			w_s3    <= w_s2;

			// split each normal component into a signed high and unsigned low half
			for (int i = 0; i < 3; i++) begin
				hi_s4[i] <= PHI_BITS'($signed(n_s3[i][CROSS_BITS-1:LO_BITS]))
					* PHI_BITS'(w_s3[i]);
				lo_s4[i] <= PLO_BITS'($signed({1'b0, n_s3[i][LO_BITS-1:0]}))
					* PLO_BITS'(w_s3[i]);
			end

			hs_s5 <= hsum_t'(hi_s4[0]) + hsum_t'(hi_s4[1]) + hsum_t'(hi_s4[2]);
			ls_s5 <= lsum_t'(lo_s4[0]) + lsum_t'(lo_s4[1]) + lsum_t'(lo_s4[2]);
		end
	end

	det_t sum;
	assign sum = (DET_BITS'(hs_s5) <<< LO_BITS) + DET_BITS'(ls_s5);
	assign neg = sum[DET_BITS-1];
endmodule

// ===== hdl/tet_boundary_face_orienter.sv =====
// ----------------------------------------------------------------------------
// tet_boundary_face_orienter
// Boundary face selection and outward orientation over stored tet meshes.
// ----------------------------------------------------------------------------
// A face reads the single-port vertex store once for each of its three nodes
// and its apex, so after each accepted face, kept or not, new input is held
// off while busy. A vertex load that follows a kept face waits until that
// face's last vertex read has been issued. Tet store lookups and the orient3d
// pipeline (five stages) overlap with the next face's reads. A kept face's
// triangle passes in turn through the tet lookup, stage 2, the vertex reads
// and the det pipeline. Results come out in order through an output register;
// stall holds the whole pipeline.
module tet_boundary_face_orienter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [12:0]                    item_index,
	input  logic signed [23:0]             coord_x,
	input  logic signed [23:0]             coord_y,
	input  logic signed [23:0]             coord_z,
	input  logic [11:0]                    corner_0,
	input  logic [11:0]                    corner_1,
	input  logic [11:0]                    corner_2,
	input  logic [11:0]                    corner_3,
	input  logic                           label_bit,
	input  logic [12:0]                    second_tet,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [11:0]                    tri_a,
	output logic [11:0]                    tri_b,
	output logic [11:0]                    tri_c,
	output logic                           was_flipped
);
	import tbfo_pkg::*;

	localparam int CW = NCORNERS * VIDX_BITS;
	localparam int LAT = 5;

	logic adv;
	assign adv = !(out_valid && out_stall);

	// stage 1: tet lookup (two-port by two single-port copies)
	logic        v_s1, outer_s1;
	face_t       f_s1;
	logic [CW-1:0] c0_rd, c1_rd;
	logic        l0_rd, l1_rd;
	logic        acc;
	logic        face_in;
	logic        busy_q;
	logic [1:0]  rcnt_q;

	assign face_in  = cmd[1];
	assign acc      = in_valid && !in_stall;

	logic tet_we;
	assign tet_we = acc && cmd_t'(cmd) == CMD_LOAD_TET;

	tbfo_ram #(.WIDTH(CW + 1), .DEPTH(MAX_TETS)) u_tet0 (
		.clk(clk), .en(adv), .we(tet_we), .addr(item_index[TIDX_BITS-1:0]),
		.wdata({corner_3, corner_2, corner_1, corner_0, label_bit}),
		.rdata({c0_rd, l0_rd})
	);
	tbfo_ram #(.WIDTH(CW + 1), .DEPTH(MAX_TETS)) u_tet1 (
		.clk(clk), .en(adv), .we(tet_we),
		.addr(tet_we ? item_index[TIDX_BITS-1:0] : second_tet[TIDX_BITS-1:0]),
		.wdata({corner_3, corner_2, corner_1, corner_0, label_bit}),
		.rdata({c1_rd, l1_rd})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc && face_in;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			outer_s1 <= cmd_t'(cmd) == CMD_FACE_OUTER;
			f_s1     <= {corner_0, corner_1, corner_2};
		end
	end

	// stage 2: boundary test and apex choice
	logic        keep;
	vidx_t       apex;
	logic [CW-1:0] cin;
	always_comb begin
		logic found;
		found = 1'b0;
		apex  = '0;
		if (outer_s1) begin
			keep = !l0_rd;
			cin  = c0_rd;
		end else begin
			keep = l0_rd != l1_rd;
			cin  = l0_rd ? c1_rd : c0_rd;
		end
		for (int k = 0; k < NCORNERS; k++) begin
			if (!found && cin[k*VIDX_BITS +: VIDX_BITS] != f_s1.a
				&& cin[k*VIDX_BITS +: VIDX_BITS] != f_s1.b
				&& cin[k*VIDX_BITS +: VIDX_BITS] != f_s1.c) begin
				found = 1'b1;
				apex  = cin[k*VIDX_BITS +: VIDX_BITS];
			end
		end
		keep = keep && found;
	end

	logic  v_s2;
	face_t f_s2;
	vidx_t d_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && keep;
		end
	end
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			f_s2 <= f_s1;
			d_s2 <= apex;
		end
	end

	// input pacing: new input held off after every accepted face, kept or not, so the vertex reads of faces do not overlap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rcnt_q <= '0;
		end else if (adv) begin
			if (acc && face_in) begin
				busy_q <= 1'b1;
				rcnt_q <= '0;
			end else if (busy_q) begin
				rcnt_q <= rcnt_q + 2'd1;
				if (rcnt_q == 2'd2) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// address sequence: a, b, c, d on counts 0..3 after stage 2
	logic [1:0] sel_q;
	logic       rd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
			rd_q  <= 1'b0;
		end else if (adv) begin
			if (v_s2 && !rd_q) begin
				rd_q  <= 1'b1;
				sel_q <= 2'd1;
			end else if (rd_q) begin
				sel_q <= sel_q + 2'd1;
				if (sel_q == 2'd3) begin
					rd_q <= 1'b0;
				end
			end
		end
	end

	// hold vertex loads while the vertex store is being read
	logic vrd_busy;
	assign vrd_busy = v_s2 || rd_q;
	assign in_stall = !adv || busy_q || (vrd_busy && cmd_t'(cmd) == CMD_LOAD_VERTEX);

	vidx_t vaddr;
	logic  vtx_we;
	assign vtx_we = acc && cmd_t'(cmd) == CMD_LOAD_VERTEX;
	always_comb begin
		vaddr = f_s2.a;
		if (vtx_we) begin
			vaddr = item_index[VIDX_BITS-1:0];
		end else if (rd_q) begin
			case (sel_q)
				2'd1:    vaddr = f_s2.b;
				2'd2:    vaddr = f_s2.c;
				default: vaddr = d_s2;
			endcase
		end
	end

	point_t vrd;
	tbfo_ram #(.WIDTH(3 * COORD_BITS), .DEPTH(MAX_VERTICES)) u_vtx (
		.clk(clk), .en(adv), .we(vtx_we), .addr(vaddr),
		.wdata({coord_x, coord_y, coord_z}), .rdata(vrd)
	);

	// collect the first three points; the apex goes to the det pipeline straight from the RAM
	point_t pa_q, pb_q, pc_q;
	logic [1:0] col_q;
	logic       colv_q;
	face_t      fc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			colv_q <= 1'b0;
		end else if (adv) begin
			if ((v_s2 && !rd_q) || rd_q) begin
				colv_q <= 1'b1;
				col_q  <= sel_q;
			end else begin
				colv_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv && colv_q) begin
			case (col_q)
				2'd0:    pa_q <= vrd;
				2'd1:    pb_q <= vrd;
				2'd2:    pc_q <= vrd;
				default: ;
			endcase
		end
		if (adv && v_s2 && !rd_q) begin
			fc_q <= f_s2;
		end
	end

	point_t pd_in;
	assign pd_in = vrd;

	// det pipeline starts when apex data arrives (pd from RAM directly)
	logic  start;
	assign start = colv_q && col_q == 2'd3;

	logic [LAT-1:0] dv_q;
	face_t          df_q [LAT];
	logic           neg;

	tbfo_det u_det (
		.clk(clk), .en(adv), .pa(pa_q), .pb(pb_q), .pc(pc_q), .pd(pd_in),
		.neg(neg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= '0;
		end else if (adv) begin
			dv_q <= {dv_q[LAT-2:0], start};
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			df_q[0] <= fc_q;
			for (int i = 1; i < LAT; i++) begin
				df_q[i] <= df_q[i-1];
			end
		end
	end

	// det output and its face reach the end of the dv_q shift register together: dv_q[4]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_q[LAT-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv && dv_q[LAT-1]) begin
			tri_a       <= df_q[LAT-1].a;
			tri_b       <= neg ? df_q[LAT-1].b : df_q[LAT-1].c;
			tri_c       <= neg ? df_q[LAT-1].c : df_q[LAT-1].b;
			was_flipped <= !neg;
		end
	end

	a_vport: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_we |-> !vrd_busy)
		else $error("vertex write during face reads");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> in_stall)
		else $error("input taken during face reads");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(tri_a))
		else $error("result lost under stall");
endmodule
